// ----- rtl/path_orbit_motion_stepper_top_defines.svh -----
// Assertion macros for the motion stepper top RTL.
`ifndef PATH_ORBIT_MOTION_STEPPER_TOP_DEFINES_SVH
`define PATH_ORBIT_MOTION_STEPPER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PMS_ASSERT(lbl, prop, msg)
`define PMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/pmstep_pkg.sv -----
package pmstep_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam logic [16:0]        PROG_ONE    = 17'd65536;
  localparam logic [31:0]        PERIOD_RST  = 32'd65536;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [3:0] {
    CFG_MODE     = 4'd0,
    CFG_START_X  = 4'd1,
    CFG_START_Y  = 4'd2,
    CFG_START_Z  = 4'd3,
    CFG_TARGET_X = 4'd4,
    CFG_TARGET_Y = 4'd5,
    CFG_TARGET_Z = 4'd6,
    CFG_PERIOD   = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] tick_delta;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]        progress_out;
    logic               path_done;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic signed [36:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic [69:0] mag;
    logic        neg;
  } mul_rsp_t;

  // arctan(2^-i) in turns, Q0.32
  function automatic logic [29:0] atan_turns(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/pmstep_chan_if.sv -----
interface pmstep_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/pmstep_div.sv -----
module pmstep_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pmstep_pkg::div_req_t req_i,
  output pmstep_pkg::div_rsp_t rsp_o
);
  import pmstep_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] dvd_q, dvd_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic [32:0] trial;
  logic        ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, dvd_q[63]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
      dvd_d = {dvd_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// ----- rtl/pmstep_mul.sv -----
module pmstep_mul (
  input  logic                clk_i,
  input  pmstep_pkg::mul_req_t req_i,
  output pmstep_pkg::mul_rsp_t rsp_o
);
  import pmstep_pkg::*;

  logic [36:0] a_mag;
  logic [32:0] b_mag;
  logic [69:0] mag_q;
  logic        neg_q;

  // sign-magnitude product, registered
  assign a_mag = req_i.a[36] ? 37'(-req_i.a) : 37'(req_i.a);
  assign b_mag = req_i.b[32] ? 33'(-req_i.b) : 33'(req_i.b);

  always_ff @(posedge clk_i) begin
    mag_q <= 70'(a_mag) * 70'(b_mag);
    neg_q <= req_i.a[36] ^ req_i.b[32];
  end

  assign rsp_o.mag = mag_q;
  assign rsp_o.neg = neg_q;

endmodule

// ----- rtl/path_orbit_motion_stepper_top.sv -----
// Path mode: one 64-step division and three multiplies; once at target the multiplies
// are skipped. Orbit mode: three 64-step divisions, a 32-step square root,
// CORDIC_STEPS rotations and 17 multiplies; on a degenerate orbit axis only the first
// division runs. One item is in work at a time; a held result stalls the next one.
// Reset clears progress and position, mode to path and period to 65536.
module path_orbit_motion_stepper_top #(
  parameter int unsigned CORDIC_STEPS = pmstep_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  pmstep_chan_if.sink   tick_i,
  pmstep_chan_if.source result_o
);
  import pmstep_pkg::*;

  `include "path_orbit_motion_stepper_top_defines.svh"

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_MULW = 7'b0001000,
    ST_SQRT = 7'b0010000,
    ST_CORD = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {DS_TURNS, DS_UX, DS_UY} dsel_e;

  typedef enum logic [4:0] {
    MS_SQX, MS_SQY, MS_KX, MS_KY, MS_KZ0, MS_KZ1, MS_DOT0, MS_DOT1, MS_W,
    MS_X0, MS_X1, MS_X2, MS_Y0, MS_Y1, MS_Y2, MS_Z0, MS_Z1, MS_PX, MS_PY, MS_PZ
  } mstep_e;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) r = 32'sd1073741824;
    else if (v < -34'sd1073741824) r = -32'sd1073741824;
    else r = 32'(v);
    return r;
  endfunction

  // configuration
  logic               mode_q;
  logic signed [31:0] start_x_q, start_y_q, start_z_q;
  logic signed [31:0] target_x_q, target_y_q, target_z_q;
  logic [31:0]        period_q;

  // control and kept state
  state_e             state_q, state_d;
  dsel_e              dsel_q, dsel_d;
  mstep_e             mstep_q, mstep_d;
  logic               out_valid_q, out_valid_d;
  result_t            res_q, res_d;
  logic [16:0]        progress_q, progress_d;
  logic signed [31:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d, cur_z_q, cur_z_d;
  logic               done_q, done_d;

  // working registers
  logic [31:0]        turns_q, turns_d;
  logic signed [32:0] vx_q, vx_d, vy_q, vy_d, vz_q, vz_d;
  logic [30:0]        ax_q, ax_d, ay_q, ay_d;
  logic               dxpos_q, dxpos_d, dyneg_q, dyneg_d;
  logic [62:0]        sq_q, sq_d;
  logic [62:0]        sqv_q, sqv_d, bit_q, bit_d;
  logic [63:0]        root_q, root_d;
  logic [4:0]         it_q, it_d;
  logic signed [31:0] ux_q, ux_d, uy_q, uy_d, sn_q, sn_d, cs_q, cs_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic               flip_q, flip_d;
  logic signed [36:0] kx_q, kx_d, ky_q, ky_d, kz_q, kz_d, dot_q, dot_d, w_q, w_d;
  logic signed [39:0] acc_q, acc_d;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // item decode helpers
  logic [63:0]        quo;
  logic [16:0]        inc_sat;
  logic [17:0]        prog_sum;
  logic               from_start;
  logic signed [31:0] base_x, base_y, base_z;
  logic signed [32:0] vx_n, vy_n, vz_n, dx, dy, dfx, dfy, dfz;
  logic [32:0]        adx, ady, amx;
  logic [1:0]         sh;
  logic signed [32:0] omc;
  logic [39:0]        m30_mag, f16_mag;
  logic signed [39:0] m30, f16;
  logic [63:0]        sq_sum;
  logic               sq_ge;
  logic [63:0]        root_n;
  logic signed [33:0] at, nx, ny, nz, fold_z;
  logic               fold_flip;

  pmstep_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pmstep_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  assign quo        = div_rsp.quotient;
  assign inc_sat    = (quo[63:16] > 48'd65536) ? PROG_ONE : quo[32:16];
  assign prog_sum   = {1'b0, progress_q} + {1'b0, inc_sat};
  assign from_start = (progress_q == '0);
  assign base_x     = from_start ? start_x_q : cur_x_q;
  assign base_y     = from_start ? start_y_q : cur_y_q;
  assign base_z     = from_start ? start_z_q : cur_z_q;
  assign vx_n       = 33'(base_x) - 33'(target_x_q);
  assign vy_n       = 33'(base_y) - 33'(target_y_q);
  assign vz_n       = 33'(base_z) - 33'(target_z_q);
  assign dx         = 33'(start_x_q) - 33'(target_x_q);
  assign dy         = 33'(start_y_q) - 33'(target_y_q);
  assign dfx        = 33'(target_x_q) - 33'(start_x_q);
  assign dfy        = 33'(target_y_q) - 33'(start_y_q);
  assign dfz        = 33'(target_z_q) - 33'(start_z_q);
  assign adx        = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady        = dy[32] ? 33'(-dy) : 33'(dy);
  assign amx        = (adx > ady) ? adx : ady;
  // bring the larger axis component below 2^31
  assign sh         = amx[32] ? 2'd2 : (amx[31] ? 2'd1 : 2'd0);
  assign omc        = 33'sd1073741824 - 33'(cs_q);

  assign m30_mag = 40'(mul_rsp.mag >> 30);
  assign m30     = mul_rsp.neg ? -$signed(m30_mag) : $signed(m30_mag);
  assign f16_mag = mul_rsp.neg ? 40'((mul_rsp.mag + 70'd65535) >> 16)
                               : 40'(mul_rsp.mag >> 16);
  assign f16     = mul_rsp.neg ? -$signed(f16_mag) : $signed(f16_mag);

  assign sq_sum = root_q + {1'b0, bit_q};
  assign sq_ge  = {1'b0, sqv_q} >= sq_sum;
  assign root_n = sq_ge ? (root_q >> 1) + {1'b0, bit_q} : (root_q >> 1);

  assign at = 34'(atan_turns(it_q));
  always_comb begin
    if (!cz_q[33]) begin
      nx = cx_q - (cy_q >>> it_q);
      ny = cy_q + (cx_q >>> it_q);
      nz = cz_q - at;
    end else begin
      nx = cx_q + (cy_q >>> it_q);
      ny = cy_q - (cx_q >>> it_q);
      nz = cz_q + at;
    end
  end

  // fold the angle into a quarter turn either side of zero
  always_comb begin
    fold_z    = 34'($signed(turns_q));
    fold_flip = 1'b0;
    if (fold_z > 34'sd1073741824) begin
      fold_z    = fold_z - 34'sd2147483648;
      fold_flip = 1'b1;
    end else if (fold_z < -34'sd1073741824) begin
      fold_z    = fold_z + 34'sd2147483648;
      fold_flip = 1'b1;
    end
  end

  // multiplier operands per step
  always_comb begin
    case (mstep_q)
      MS_SQX:  begin mul_req.a = 37'(ax_q);  mul_req.b = 33'(ax_q);    end
      MS_SQY:  begin mul_req.a = 37'(ay_q);  mul_req.b = 33'(ay_q);    end
      MS_KX:   begin mul_req.a = 37'(vz_q);  mul_req.b = 33'(uy_q);    end
      MS_KY:   begin mul_req.a = 37'(vz_q);  mul_req.b = 33'(ux_q);    end
      MS_KZ0:  begin mul_req.a = 37'(vy_q);  mul_req.b = 33'(ux_q);    end
      MS_KZ1:  begin mul_req.a = 37'(vx_q);  mul_req.b = 33'(uy_q);    end
      MS_DOT0: begin mul_req.a = 37'(vx_q);  mul_req.b = 33'(ux_q);    end
      MS_DOT1: begin mul_req.a = 37'(vy_q);  mul_req.b = 33'(uy_q);    end
      MS_W:    begin mul_req.a = dot_q;      mul_req.b = omc;          end
      MS_X0:   begin mul_req.a = 37'(vx_q);  mul_req.b = 33'(cs_q);    end
      MS_X1:   begin mul_req.a = kx_q;       mul_req.b = 33'(sn_q);    end
      MS_X2:   begin mul_req.a = w_q;        mul_req.b = 33'(ux_q);    end
      MS_Y0:   begin mul_req.a = 37'(vy_q);  mul_req.b = 33'(cs_q);    end
      MS_Y1:   begin mul_req.a = ky_q;       mul_req.b = 33'(sn_q);    end
      MS_Y2:   begin mul_req.a = w_q;        mul_req.b = 33'(uy_q);    end
      MS_Z0:   begin mul_req.a = 37'(vz_q);  mul_req.b = 33'(cs_q);    end
      MS_Z1:   begin mul_req.a = kz_q;       mul_req.b = 33'(sn_q);    end
      MS_PX:   begin mul_req.a = 37'(dfx);   mul_req.b = 33'(progress_q); end
      MS_PY:   begin mul_req.a = 37'(dfy);   mul_req.b = 33'(progress_q); end
      MS_PZ:   begin mul_req.a = 37'(dfz);   mul_req.b = 33'(progress_q); end
      default: begin mul_req.a = '0;         mul_req.b = '0;           end
    endcase
  end

  assign tick_i.ready    = (state_q == ST_IDLE);
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = res_q;

  always_comb begin
    state_d     = state_q;
    dsel_d      = dsel_q;
    mstep_d     = mstep_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    progress_d  = progress_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    cur_z_d     = cur_z_q;
    done_d      = done_q;
    turns_d     = turns_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    vz_d        = vz_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    dxpos_d     = dxpos_q;
    dyneg_d     = dyneg_q;
    sq_d        = sq_q;
    sqv_d       = sqv_q;
    bit_d       = bit_q;
    root_d      = root_q;
    it_d        = it_q;
    ux_d        = ux_q;
    uy_d        = uy_q;
    sn_d        = sn_q;
    cs_d        = cs_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    flip_d      = flip_q;
    kx_d        = kx_q;
    ky_d        = ky_q;
    kz_d        = kz_q;
    dot_d       = dot_q;
    w_d         = w_q;
    acc_d       = acc_q;
    div_req     = '0;

    if (result_o.ready) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (tick_i.valid) begin
          div_req.start    = 1'b1;
          div_req.dividend = {tick_i.payload.tick_delta, 32'd0};
          div_req.divisor  = (period_q == '0) ? 32'd1 : period_q;
          dsel_d           = DS_TURNS;
          state_d          = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          case (dsel_q)
            DS_TURNS: begin
              turns_d = quo[31:0];
              if (!mode_q) begin
                done_d = 1'b1;
                if (progress_q >= PROG_ONE) begin
                  progress_d = PROG_ONE;
                  state_d    = ST_OUT;
                end else if (prog_sum >= {1'b0, PROG_ONE}) begin
                  progress_d = PROG_ONE;
                  cur_x_d    = target_x_q;
                  cur_y_d    = target_y_q;
                  cur_z_d    = target_z_q;
                  state_d    = ST_OUT;
                end else begin
                  done_d     = 1'b0;
                  progress_d = prog_sum[16:0];
                  mstep_d    = MS_PX;
                  state_d    = ST_MUL;
                end
              end else begin
                done_d     = 1'b0;
                progress_d = {1'b0, progress_q[15:0] + quo[31:16]};
                vx_d       = vx_n;
                vy_d       = vy_n;
                vz_d       = vz_n;
                if (dx == '0 && dy == '0) begin
                  // degenerate axis: hold the base point
                  cur_x_d = base_x;
                  cur_y_d = base_y;
                  cur_z_d = base_z;
                  state_d = ST_OUT;
                end else begin
                  ax_d    = 31'(adx >> sh);
                  ay_d    = 31'(ady >> sh);
                  dxpos_d = !dx[32] && (dx != '0);
                  dyneg_d = dy[32];
                  mstep_d = MS_SQX;
                  state_d = ST_MUL;
                end
              end
            end
            DS_UX: begin
              ux_d = dyneg_q ? -$signed({1'b0, quo[30:0]}) : $signed({1'b0, quo[30:0]});
              div_req.start    = 1'b1;
              div_req.dividend = {3'd0, ax_q, 30'd0};
              div_req.divisor  = root_q[31:0];
              dsel_d           = DS_UY;
            end
            DS_UY: begin
              uy_d    = dxpos_q ? -$signed({1'b0, quo[30:0]}) : $signed({1'b0, quo[30:0]});
              cx_d    = CORDIC_GAIN;
              cy_d    = '0;
              cz_d    = fold_z;
              flip_d  = fold_flip;
              it_d    = '0;
              state_d = ST_CORD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_MUL: state_d = ST_MULW;

      ST_MULW: begin
        state_d = ST_MUL;
        case (mstep_q)
          MS_SQX: begin
            sq_d    = mul_rsp.mag[62:0];
            mstep_d = MS_SQY;
          end
          MS_SQY: begin
            sq_d    = sq_q + mul_rsp.mag[62:0];
            sqv_d   = sq_q + mul_rsp.mag[62:0];
            root_d  = '0;
            bit_d   = {1'b1, 62'd0};
            it_d    = '0;
            state_d = ST_SQRT;
          end
          MS_KX: begin
            kx_d    = 37'(m30);
            mstep_d = MS_KY;
          end
          MS_KY: begin
            ky_d    = 37'(-m30);
            mstep_d = MS_KZ0;
          end
          MS_KZ0: begin
            kz_d    = 37'(m30);
            mstep_d = MS_KZ1;
          end
          MS_KZ1: begin
            kz_d    = 37'(40'(kz_q) - m30);
            mstep_d = MS_DOT0;
          end
          MS_DOT0: begin
            dot_d   = 37'(m30);
            mstep_d = MS_DOT1;
          end
          MS_DOT1: begin
            dot_d   = 37'(40'(dot_q) + m30);
            mstep_d = MS_W;
          end
          MS_W: begin
            w_d     = 37'(m30);
            mstep_d = MS_X0;
          end
          MS_X0: begin
            acc_d   = 40'(target_x_q) + m30;
            mstep_d = MS_X1;
          end
          MS_X1: begin
            acc_d   = acc_q + m30;
            mstep_d = MS_X2;
          end
          MS_X2: begin
            cur_x_d = sat32(acc_q + m30);
            mstep_d = MS_Y0;
          end
          MS_Y0: begin
            acc_d   = 40'(target_y_q) + m30;
            mstep_d = MS_Y1;
          end
          MS_Y1: begin
            acc_d   = acc_q + m30;
            mstep_d = MS_Y2;
          end
          MS_Y2: begin
            cur_y_d = sat32(acc_q + m30);
            mstep_d = MS_Z0;
          end
          MS_Z0: begin
            acc_d   = 40'(target_z_q) + m30;
            mstep_d = MS_Z1;
          end
          MS_Z1: begin
            cur_z_d = sat32(acc_q + m30);
            state_d = ST_OUT;
          end
          MS_PX: begin
            cur_x_d = sat32(40'(start_x_q) + f16);
            mstep_d = MS_PY;
          end
          MS_PY: begin
            cur_y_d = sat32(40'(start_y_q) + f16);
            mstep_d = MS_PZ;
          end
          MS_PZ: begin
            cur_z_d = sat32(40'(start_z_q) + f16);
            state_d = ST_OUT;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_SQRT: begin
        if (sq_ge) sqv_d = 63'({1'b0, sqv_q} - sq_sum);
        root_d = root_n;
        bit_d  = bit_q >> 2;
        it_d   = it_q + 5'd1;
        if (it_q == 5'd31) begin
          div_req.start    = 1'b1;
          div_req.dividend = {3'd0, ay_q, 30'd0};
          div_req.divisor  = root_n[31:0];
          dsel_d           = DS_UX;
          state_d          = ST_DIV;
        end
      end

      ST_CORD: begin
        cx_d = nx;
        cy_d = ny;
        cz_d = nz;
        it_d = it_q + 5'd1;
        if (it_q == 5'(CORDIC_STEPS - 1)) begin
          cs_d    = clamp30(flip_q ? -nx : nx);
          sn_d    = clamp30(flip_q ? -ny : ny);
          mstep_d = MS_KX;
          state_d = ST_MUL;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d        = 1'b1;
          res_d.pos_x        = cur_x_q;
          res_d.pos_y        = cur_y_q;
          res_d.pos_z        = cur_z_q;
          res_d.progress_out = progress_q;
          res_d.path_done    = done_q;
          state_d            = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
      start_x_q   <= '0;
      start_y_q   <= '0;
      start_z_q   <= '0;
      target_x_q  <= '0;
      target_y_q  <= '0;
      target_z_q  <= '0;
      period_q    <= PERIOD_RST;
      progress_q  <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_z_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      progress_q  <= progress_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      cur_z_q     <= cur_z_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:     mode_q     <= cfg_data_i[0];
          CFG_START_X:  start_x_q  <= cfg_data_i;
          CFG_START_Y:  start_y_q  <= cfg_data_i;
          CFG_START_Z:  start_z_q  <= cfg_data_i;
          CFG_TARGET_X: target_x_q <= cfg_data_i;
          CFG_TARGET_Y: target_y_q <= cfg_data_i;
          CFG_TARGET_Z: target_z_q <= cfg_data_i;
          CFG_PERIOD:   period_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dsel_q  <= dsel_d;
    mstep_q <= mstep_d;
    res_q   <= res_d;
    turns_q <= turns_d;
    vx_q    <= vx_d;
    vy_q    <= vy_d;
    vz_q    <= vz_d;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    dxpos_q <= dxpos_d;
    dyneg_q <= dyneg_d;
    sq_q    <= sq_d;
    sqv_q   <= sqv_d;
    bit_q   <= bit_d;
    root_q  <= root_d;
    it_q    <= it_d;
    ux_q    <= ux_d;
    uy_q    <= uy_d;
    sn_q    <= sn_d;
    cs_q    <= cs_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    flip_q  <= flip_d;
    kx_q    <= kx_d;
    ky_q    <= ky_d;
    kz_q    <= kz_d;
    dot_q   <= dot_d;
    w_q     <= w_d;
    acc_q   <= acc_d;
  end

  `PMS_ASSERT(a_busy_after_accept, tick_i.valid && tick_i.ready |=> !tick_i.ready, "ready after accept")
  `PMS_ASSERT_ALWAYS(a_progress_range, progress_q <= PROG_ONE, "progress above one")
  `PMS_ASSERT(a_done_at_one, result_o.valid && result_o.payload.path_done |-> result_o.payload.progress_out == PROG_ONE, "done without full progress")
  `PMS_ASSERT(a_div_done_in_div, div_rsp.done |-> state_q == ST_DIV, "divider finished outside divide state")

endmodule
